### design/frrl_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// frrl_pkg
// Shared types and constants of the frequency ranked recent list: field
// widths, operation codes, table entry layout and controller states.
// ----------------------------------------------------------------------------
package frrl_pkg;

   localparam int DATA_W = 32;
   localparam int USES_W = 16;
   localparam int STEP_W = 8;

   localparam logic [USES_W-1:0] USES_MAX = {USES_W{1'b1}};

   localparam logic OP_ADD   = 1'b0;
   localparam logic OP_FETCH = 1'b1;

   typedef struct packed {
      logic [DATA_W-1:0] key;
      logic [DATA_W-1:0] ident;
      logic [DATA_W-1:0] payload;
      logic [USES_W-1:0] uses;
      logic [DATA_W-1:0] stamp;
   } frrl_entry_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ADD_SCAN,
      ST_SHIFT,
      ST_APPEND,
      ST_MOD,
      ST_RANK_CAND,
      ST_RANK_LOAD,
      ST_RANK_CMP,
      ST_RESP
   } frrl_state_type;

endpackage
`default_nettype wire

### design/frequency_ranked_recent_list_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// frequency_ranked_recent_list_core
// Recent list of up to 2*VISIBLE_ITEMS entries, ranked by use count, with
// least recent eviction and a wrapping read position over the top entries.
// ----------------------------------------------------------------------------
// The block keeps all entries in one single-port-read, single-port-write table
// memory with a registered read port, and works on one request at a time.
// An add transfer (operation 0) scans the used entries for the key: on a hit
// the entry's count is bumped (saturating) and its stamp refreshed; on a miss
// with a full table the least recent entry is removed by moving the later
// entries down one place, then the new entry is appended with count one. Every
// add clears the read position and returns a result transfer with valid_res
// low and zero fields. A fetch transfer (operation 1) advances the read
// position by step-1 (step 0 acts as 1) modulo L = min(VISIBLE_ITEMS, used)
// and returns the entry of that rank, counts highest first, ties in table
// order. An add runs the key scan, then on a full-table miss the move-down,
// and then the append. A fetch runs a restoring modulo of position plus step,
// one bit at a time, then the rank search: each entry in table order is
// taken as candidate and compared with every used entry until the number
// ranked ahead of it equals the target rank. Either request then loads the
// output register. The table memory delivers one entry per cycle to the
// compare logic. The request side is held off (req_stall) while a request
// is in work; a finished result waits in the output register and does not
// block the next request transfer.
// ----------------------------------------------------------------------------
module frequency_ranked_recent_list_core #(
   parameter int VISIBLE_ITEMS = 8
) (
   input  wire                          clock,
   input  wire                          reset,
   // request channel
   input  wire                          req_valid,
   output logic                         req_stall,
   input  wire                          req_operation,
   input  wire  [frrl_pkg::DATA_W-1:0]  req_key,
   input  wire  [frrl_pkg::DATA_W-1:0]  req_ident,
   input  wire  [frrl_pkg::DATA_W-1:0]  req_payload,
   input  wire  [frrl_pkg::STEP_W-1:0]  req_step,
   // response channel
   output logic                         rsp_valid,
   input  wire                          rsp_stall,
   output logic                         rsp_valid_res,
   output logic [frrl_pkg::DATA_W-1:0]  rsp_out_key,
   output logic [frrl_pkg::DATA_W-1:0]  rsp_out_ident,
   output logic [frrl_pkg::DATA_W-1:0]  rsp_out_payload
);

   import frrl_pkg::*;

   // table geometry
   localparam int TABLE_SIZE = 2 * VISIBLE_ITEMS;
   localparam int IDX_W      = $clog2(TABLE_SIZE);
   localparam int CNT_W      = $clog2(TABLE_SIZE + 1);
   localparam int POS_W      = $clog2(VISIBLE_ITEMS + 1);
   // read position plus step-1, and the shifted divisor of the modulo step
   localparam int SUM_W      = ((POS_W > STEP_W) ? POS_W : STEP_W) + 1;
   localparam int DIV_W      = SUM_W + POS_W;
   localparam int BIT_W      = $clog2(SUM_W);

   localparam logic [CNT_W-1:0] TABLE_FULL  = CNT_W'(TABLE_SIZE);
   localparam logic [CNT_W-1:0] VIS_CNT     = CNT_W'(VISIBLE_ITEMS);
   localparam logic [POS_W-1:0] VIS_POS     = POS_W'(VISIBLE_ITEMS);
   localparam logic [BIT_W-1:0] BIT_TOP     = BIT_W'(SUM_W - 1);

   // table memory
   frrl_entry_type mem_ff [TABLE_SIZE];
   frrl_entry_type rd_data_ff;
   logic                 rd_en;
   logic [IDX_W-1:0]     rd_addr;
   logic                 wr_en;
   logic [IDX_W-1:0]     wr_addr;
   frrl_entry_type       wr_data;

   // control state
   frrl_state_type       state_ff, state_in;
   logic [CNT_W-1:0]     used_ff, used_in;
   logic [POS_W-1:0]     rdpos_ff, rdpos_in;
   logic [DATA_W-1:0]    tick_ff, tick_in;
   logic                 rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0]     rd_idx_ff, rd_idx_in;

   // working registers
   logic [CNT_W-1:0]     scan_ff, scan_in;
   logic [DATA_W-1:0]    op_key_ff, op_key_in;
   logic [DATA_W-1:0]    op_ident_ff, op_ident_in;
   logic [DATA_W-1:0]    op_payload_ff, op_payload_in;
   logic [IDX_W-1:0]     oldest_ff, oldest_in;
   logic [DATA_W-1:0]    ostamp_ff, ostamp_in;
   logic [SUM_W-1:0]     rem_ff, rem_in;
   logic [POS_W-1:0]     lim_ff, lim_in;
   logic [BIT_W-1:0]     bit_ff, bit_in;
   logic [POS_W-1:0]     target_ff, target_in;
   logic [IDX_W-1:0]     cand_ptr_ff, cand_ptr_in;
   frrl_entry_type       cand_ff, cand_in;
   logic [IDX_W-1:0]     cand_idx_ff, cand_idx_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 res_valid_ff, res_valid_in;

   // response register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_valid_res_ff;
   logic [DATA_W-1:0]    rsp_key_ff;
   logic [DATA_W-1:0]    rsp_ident_ff;
   logic [DATA_W-1:0]    rsp_payload_ff;
   logic                 rsp_load;

   // helpers
   logic                 req_fire;
   logic                 add_hit;
   logic [USES_W-1:0]    uses_bump;
   logic [POS_W-1:0]     lim_now;
   logic [POS_W-1:0]     pos_start;
   logic [STEP_W-1:0]    step_adv;
   logic [DIV_W-1:0]     div_sh;
   logic [SUM_W-1:0]     rem_next;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_fire  = req_valid && !req_stall;

   assign add_hit   = rd_vld_ff && (rd_data_ff.key == op_key_ff);
   assign uses_bump = (rd_data_ff.uses == USES_MAX) ? rd_data_ff.uses
                                                    : rd_data_ff.uses + USES_W'(1);

   // shown range and starting position of a fetch
   assign lim_now   = (used_ff < VIS_CNT) ? used_ff[POS_W-1:0] : VIS_POS;
   assign pos_start = (rdpos_ff >= lim_now) ? '0 : rdpos_ff;
   assign step_adv  = (req_step == '0) ? '0 : req_step - STEP_W'(1);

   // one restoring step of the position modulo
   assign div_sh    = DIV_W'(lim_ff) << bit_ff;
   assign rem_next  = (DIV_W'(rem_ff) >= div_sh) ? rem_ff - div_sh[SUM_W-1:0] : rem_ff;

   // ---------------------------------------------------------------------
   // Table memory: one write port, one registered read port
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   // ---------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         used_ff      <= '0;
         rdpos_ff     <= '0;
         tick_ff      <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         rdpos_ff     <= rdpos_in;
         tick_ff      <= tick_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff     <= rd_idx_in;
      scan_ff       <= scan_in;
      op_key_ff     <= op_key_in;
      op_ident_ff   <= op_ident_in;
      op_payload_ff <= op_payload_in;
      oldest_ff     <= oldest_in;
      ostamp_ff     <= ostamp_in;
      rem_ff        <= rem_in;
      lim_ff        <= lim_in;
      bit_ff        <= bit_in;
      target_ff     <= target_in;
      cand_ptr_ff   <= cand_ptr_in;
      cand_ff       <= cand_in;
      cand_idx_ff   <= cand_idx_in;
      count_ff      <= count_in;
      res_valid_ff  <= res_valid_in;
      if (rsp_load) begin
         // adds and empty fetches return zero fields
         rsp_valid_res_ff <= res_valid_ff;
         rsp_key_ff       <= res_valid_ff ? cand_ff.key     : '0;
         rsp_ident_ff     <= res_valid_ff ? cand_ff.ident   : '0;
         rsp_payload_ff   <= res_valid_ff ? cand_ff.payload : '0;
      end
   end

   // ---------------------------------------------------------------------
   // Controller
   // ---------------------------------------------------------------------
   always_comb begin
      state_in      = state_ff;
      used_in       = used_ff;
      rdpos_in      = rdpos_ff;
      tick_in       = tick_ff;
      scan_in       = scan_ff;
      op_key_in     = op_key_ff;
      op_ident_in   = op_ident_ff;
      op_payload_in = op_payload_ff;
      oldest_in     = oldest_ff;
      ostamp_in     = ostamp_ff;
      rem_in        = rem_ff;
      lim_in        = lim_ff;
      bit_in        = bit_ff;
      target_in     = target_ff;
      cand_ptr_in   = cand_ptr_ff;
      cand_in       = cand_ff;
      cand_idx_in   = cand_idx_ff;
      count_in      = count_ff;
      res_valid_in  = res_valid_ff;
      rd_en         = 1'b0;
      rd_addr       = scan_ff[IDX_W-1:0];
      wr_en         = 1'b0;
      wr_addr       = rd_idx_ff;
      wr_data       = rd_data_ff;
      rsp_load      = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               op_key_in     = req_key;
               op_ident_in   = req_ident;
               op_payload_in = req_payload;
               scan_in       = '0;
               res_valid_in  = 1'b0;
               if (req_operation == OP_ADD) begin
                  state_in = ST_ADD_SCAN;
               end else if (lim_now == '0) begin
                  // empty table: nothing to show
                  rdpos_in = '0;
                  state_in = ST_RESP;
               end else begin
                  rem_in   = SUM_W'(pos_start) + SUM_W'(step_adv);
                  lim_in   = lim_now;
                  bit_in   = BIT_TOP;
                  state_in = ST_MOD;
               end
            end
         end

         ST_ADD_SCAN: begin
            if (rd_vld_ff) begin
               if (add_hit) begin
                  // touch: bump count, refresh stamp
                  wr_en         = 1'b1;
                  wr_addr       = rd_idx_ff;
                  wr_data.uses  = uses_bump;
                  wr_data.stamp = tick_ff;
                  tick_in       = tick_ff + DATA_W'(1);
                  rdpos_in      = '0;
                  state_in      = ST_RESP;
               end else if (rd_idx_ff == '0 || rd_data_ff.stamp < ostamp_ff) begin
                  // first entry with the smallest stamp wins
                  oldest_in = rd_idx_ff;
                  ostamp_in = rd_data_ff.stamp;
               end
            end
            if (!add_hit) begin
               if (scan_ff < used_ff) begin
                  rd_en   = 1'b1;
                  scan_in = scan_ff + CNT_W'(1);
               end else if (!rd_vld_ff) begin
                  if (used_ff == TABLE_FULL) begin
                     scan_in  = CNT_W'(oldest_ff) + CNT_W'(1);
                     state_in = ST_SHIFT;
                  end else begin
                     state_in = ST_APPEND;
                  end
               end
            end
         end

         ST_SHIFT: begin
            // move each entry after the evicted one down one place
            if (rd_vld_ff) begin
               wr_en   = 1'b1;
               wr_addr = rd_idx_ff - IDX_W'(1);
            end
            if (scan_ff < used_ff) begin
               rd_en   = 1'b1;
               scan_in = scan_ff + CNT_W'(1);
            end else if (!rd_vld_ff) begin
               used_in  = used_ff - CNT_W'(1);
               state_in = ST_APPEND;
            end
         end

         ST_APPEND: begin
            wr_en           = 1'b1;
            wr_addr         = used_ff[IDX_W-1:0];
            wr_data.key     = op_key_ff;
            wr_data.ident   = op_ident_ff;
            wr_data.payload = op_payload_ff;
            wr_data.uses    = USES_W'(1);
            wr_data.stamp   = tick_ff;
            used_in         = used_ff + CNT_W'(1);
            tick_in         = tick_ff + DATA_W'(1);
            rdpos_in        = '0;
            state_in        = ST_RESP;
         end

         ST_MOD: begin
            rem_in = rem_next;
            if (bit_ff == '0) begin
               target_in   = rem_next[POS_W-1:0];
               rdpos_in    = rem_next[POS_W-1:0] + POS_W'(1);
               cand_ptr_in = '0;
               state_in    = ST_RANK_CAND;
            end else begin
               bit_in = bit_ff - BIT_W'(1);
            end
         end

         ST_RANK_CAND: begin
            rd_en    = 1'b1;
            rd_addr  = cand_ptr_ff;
            state_in = ST_RANK_LOAD;
         end

         ST_RANK_LOAD: begin
            cand_in     = rd_data_ff;
            cand_idx_in = rd_idx_ff;
            count_in    = '0;
            scan_in     = '0;
            state_in    = ST_RANK_CMP;
         end

         ST_RANK_CMP: begin
            // count entries ranked ahead of the candidate
            if (rd_vld_ff && (rd_data_ff.uses > cand_ff.uses ||
                              (rd_data_ff.uses == cand_ff.uses && rd_idx_ff < cand_idx_ff))) begin
               count_in = count_ff + CNT_W'(1);
            end
            if (scan_ff < used_ff) begin
               rd_en   = 1'b1;
               scan_in = scan_ff + CNT_W'(1);
            end else if (!rd_vld_ff) begin
               if (count_ff == CNT_W'(target_ff)) begin
                  res_valid_in = 1'b1;
                  state_in     = ST_RESP;
               end else begin
                  cand_ptr_in = cand_ptr_ff + IDX_W'(1);
                  state_in    = ST_RANK_CAND;
               end
            end
         end

         ST_RESP: begin
            // hold until the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rd_vld_in = rd_en;
   assign rd_idx_in = rd_en ? rd_addr : rd_idx_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_valid_res   = rsp_valid_res_ff;
   assign rsp_out_key     = rsp_key_ff;
   assign rsp_out_ident   = rsp_ident_ff;
   assign rsp_out_payload = rsp_payload_ff;

endmodule
`default_nettype wire
